@@ hw/rtl/pps_pkg.sv @@
// pps_pkg: shared types and constants for the palette pixel scaler.
// Used by the front, queue, back and core scaler modules and by the bench; no dependencies.
`default_nettype none

package pps_pkg;

   // Fixed field widths of the request and response items
   localparam int ADDR_W   = 17;
   localparam int COLOUR_W = 16;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [COLOUR_W-1:0] colour_type;

   // Request function codes (code three is unused and ignored)
   typedef enum logic [1:0] {
      FUNC_PIXEL       = 2'd0,
      FUNC_PAL_WRITE   = 2'd1,
      FUNC_FRAME_START = 2'd2
   } pps_func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] pix_index;
      logic       last_in_row;
      logic [7:0] first_row;
      logic [3:0] pal_slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      addr_type   dest_addr;
      colour_type colour;
      logic       last;
   } rsp_payload_type;

   // Work queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      addr_type   addr;
      colour_type colour;
      logic       dup;
   } pps_entry_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   nonempty;
   } pps_queue_status_type;

   // Back end write sequencer
   typedef enum logic {
      BACK_FIRST  = 1'b0,
      BACK_SECOND = 1'b1
   } pps_back_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/pps_stream_if.sv @@
// pps_stream_if: valid/ready stream channel carrying one request or response.
// Payload type comes from pps_pkg at the point of instantiation.
`default_nettype none

interface pps_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pps_ram.sv @@
// pps_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module pps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pps_front.sv @@
// pps_front: accepts requests, decodes them, tracks destination position and
// looks up the palette. Depends on pps_pkg, pps_stream_if and pps_ram.
`default_nettype none

module pps_front #(
   parameter int DEST_WIDTH    = 320,
   parameter int DEST_HEIGHT   = 240,
   parameter int REPEAT_PERIOD = 5,
   parameter int PAL_ENTRIES   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   pps_stream_if.sink                   req_ch,
   input  pps_pkg::pps_queue_status_type q_status,
   output logic                         push,
   output pps_pkg::pps_entry_type       push_entry
);

   localparam int CW  = $clog2(DEST_WIDTH + 1);
   localparam int RW  = $clog2(DEST_HEIGHT + 1);
   localparam int PW  = $clog2(REPEAT_PERIOD);
   localparam int AW  = $clog2((DEST_HEIGHT + 1) * DEST_WIDTH + 1);
   localparam int PAW = $clog2(PAL_ENTRIES);

   localparam logic [CW-1:0] WIDTH_C    = CW'(DEST_WIDTH);
   localparam logic [RW:0]   HEIGHT_X   = (RW + 1)'(DEST_HEIGHT);
   localparam logic [RW:0]   ONE_ROW    = (RW + 1)'(1);
   localparam logic [RW:0]   TWO_ROWS   = (RW + 1)'(2);
   localparam logic [AW-1:0] ROW_STEP   = AW'(DEST_WIDTH);
   localparam logic [AW-1:0] ROW_STEP2  = AW'(2 * DEST_WIDTH);
   localparam logic [PW-1:0] PHASE_LAST = PW'(REPEAT_PERIOD - 1);
   localparam logic [8:0]    PAL_LIMIT  = 9'(PAL_ENTRIES);

   // Row number modulo the repeat period: compare and subtract shifted periods
   function automatic logic [PW-1:0] phase_of(input logic [7:0] row);
      logic [11:0] rem;
      logic [11:0] step;
      rem = {4'b0, row};
      for (int k = 7; k >= 0; k--) begin
         step = 12'(REPEAT_PERIOD) << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[PW-1:0];
   endfunction

   function automatic pps_pkg::colour_type rgb565(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] base_ff, base_in;
   logic [PW-1:0] phase_ff, phase_in;

   logic               s1_valid_ff, s1_valid_in;
   pps_pkg::addr_type  s1_addr_ff;
   logic               s1_dup_ff;
   logic               s1_zero_ff;

   localparam int QOCC_W = pps_pkg::QUEUE_CNT_W + 1;
   logic                 req_accept;
   logic [QOCC_W-1:0]    occupancy;

   logic                 repeat_row;
   logic                 in_range;
   logic                 dup;
   logic                 idx_ok;
   logic                 slot_ok;
   logic [RW:0]          row_sum;
   logic [RW:0]          row_next;
   logic [AW-1:0]        addr_full;
   logic                 pal_we;
   pps_pkg::colour_type  pal_rd_data;

   // Room for this request and the one already in the lookup stage
   assign occupancy    = QOCC_W'(q_status.count) + QOCC_W'(s1_valid_ff);
   assign req_ch.ready = occupancy < QOCC_W'(pps_pkg::QUEUE_DEPTH);
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Position decode for a pixel
   assign repeat_row = (phase_ff == '0);
   assign in_range   = ({1'b0, row_ff} < HEIGHT_X) && (col_ff < WIDTH_C);
   assign row_next   = {1'b0, row_ff} + ONE_ROW;
   assign dup        = repeat_row && (row_next < HEIGHT_X);
   assign row_sum    = {1'b0, row_ff} + (repeat_row ? TWO_ROWS : ONE_ROW);
   assign addr_full  = base_ff + AW'(col_ff);
   assign idx_ok     = 9'(req_ch.payload.pix_index) < PAL_LIMIT;
   assign slot_ok    = 9'(req_ch.payload.pal_slot) < PAL_LIMIT;

   // Request decode and counter update
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      phase_in    = phase_ff;
      s1_valid_in = 1'b0;
      pal_we      = 1'b0;
      if (req_accept) begin
         unique case (req_ch.payload.func)
            pps_pkg::FUNC_PIXEL: begin
               s1_valid_in = in_range;
               if (col_ff < WIDTH_C) begin
                  col_in = col_ff + CW'(1);
               end
               if (req_ch.payload.last_in_row) begin
                  col_in   = '0;
                  row_in   = (row_sum > HEIGHT_X) ? RW'(DEST_HEIGHT) : row_sum[RW-1:0];
                  base_in  = base_ff + (repeat_row ? ROW_STEP2 : ROW_STEP);
                  phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + PW'(1);
               end
            end
            pps_pkg::FUNC_PAL_WRITE: begin
               pal_we = slot_ok;
            end
            pps_pkg::FUNC_FRAME_START: begin
               col_in   = '0;
               row_in   = '0;
               base_in  = '0;
               phase_in = phase_of(req_ch.payload.first_row);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         base_ff     <= '0;
         phase_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         base_ff     <= base_in;
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Lookup stage payload, aligned with the palette read data
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff <= pps_pkg::addr_type'(addr_full);
         s1_dup_ff  <= dup;
         s1_zero_ff <= !idx_ok;
      end
   end

   // Palette store
   pps_ram #(
      .WIDTH (pps_pkg::COLOUR_W),
      .DEPTH (PAL_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (PAW'(req_ch.payload.pal_slot)),
      .wr_data (rgb565(req_ch.payload.red, req_ch.payload.green, req_ch.payload.blue)),
      .rd_addr (PAW'(req_ch.payload.pix_index)),
      .rd_data (pal_rd_data)
   );

   assign push              = s1_valid_ff;
   assign push_entry.addr   = s1_addr_ff;
   assign push_entry.colour = s1_zero_ff ? '0 : pal_rd_data;
   assign push_entry.dup    = s1_dup_ff;

   // Counters saturate at the destination size
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} <= HEIGHT_X)
      else $error("destination row beyond height");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= WIDTH_C)
      else $error("destination column beyond width");

endmodule

`default_nettype wire

@@ hw/rtl/pps_queue.sv @@
// pps_queue: short FIFO of looked-up pixels between the front and back ends.
// Depends on pps_pkg.
`default_nettype none

module pps_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  pps_pkg::pps_entry_type        push_entry,
   input  logic                          pop,
   output pps_pkg::pps_entry_type        head,
   output pps_pkg::pps_queue_status_type status
);

   localparam int PTR_W = pps_pkg::QUEUE_PTR_W;
   localparam int CNT_W = pps_pkg::QUEUE_CNT_W;

   pps_pkg::pps_entry_type entry_ff [pps_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head            = entry_ff[rd_ptr_ff];
   assign status.count    = count_ff;
   assign status.nonempty = (count_ff != '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != CNT_W'(pps_pkg::QUEUE_DEPTH))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

endmodule

`default_nettype wire

@@ hw/rtl/pps_back.sv @@
// pps_back: turns queued pixels into one or two destination writes and holds
// the response register. Depends on pps_pkg and pps_stream_if.
`default_nettype none

module pps_back #(
   parameter int DEST_WIDTH = 320
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pps_pkg::pps_entry_type        head,
   input  pps_pkg::pps_queue_status_type q_status,
   output logic                          pop,
   pps_stream_if.source                  rsp_ch
);

   localparam pps_pkg::addr_type ROW_OFFSET = pps_pkg::addr_type'(DEST_WIDTH);

   pps_pkg::pps_back_state_type state_ff, state_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   pps_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic                      load;
   logic                      emit;

   // Response register is free or being drained this cycle
   assign load = !rsp_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pps_pkg::BACK_FIRST: begin
            if (load && q_status.nonempty && head.dup) begin
               state_in = pps_pkg::BACK_SECOND;
            end
         end
         pps_pkg::BACK_SECOND: begin
            if (load) begin
               state_in = pps_pkg::BACK_FIRST;
            end
         end
         default: state_in = pps_pkg::BACK_FIRST;
      endcase
   end

   // Write generation
   always_comb begin
      emit                     = 1'b0;
      pop                      = 1'b0;
      rsp_payload_in.dest_addr = head.addr;
      rsp_payload_in.colour    = head.colour;
      rsp_payload_in.last      = 1'b1;
      unique case (state_ff)
         pps_pkg::BACK_FIRST: begin
            emit                = load && q_status.nonempty;
            pop                 = emit && !head.dup;
            rsp_payload_in.last = !head.dup;
         end
         pps_pkg::BACK_SECOND: begin
            emit                     = load;
            pop                      = load;
            rsp_payload_in.dest_addr = head.addr + ROW_OFFSET;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pps_pkg::BACK_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   // A first write without last always has its duplicate pending
   a_dup_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.last |-> state_ff == pps_pkg::BACK_SECOND)
      else $error("first write of a pair shown without duplicate pending");

endmodule

`default_nettype wire

@@ hw/rtl/palette_pixel_scaler_core.sv @@
// Palette pixel scaler: palette lookup and vertical line repeat to a fixed-size frame.
// Throughput: one request per cycle while the work queue has room; a pixel on a repeated row
//   needs two responses, and the four-entry work queue absorbs the burst before requests stall.
// A result passes the lookup stage register, the work queue and the response register in that order.
// Reset clears position counters, row phase, queue and handshake state; the
//   palette store is undefined until written.
`default_nettype none

module palette_pixel_scaler_core #(
   parameter int DEST_WIDTH    = 320,
   parameter int DEST_HEIGHT   = 240,
   parameter int REPEAT_PERIOD = 5,
   parameter int PAL_ENTRIES   = 16
) (
   input  logic         clock,
   input  logic         reset,
   pps_stream_if.sink   req_ch,
   pps_stream_if.source rsp_ch
);

   logic                          push;
   logic                          pop;
   pps_pkg::pps_entry_type        push_entry;
   pps_pkg::pps_entry_type        head;
   pps_pkg::pps_queue_status_type q_status;

   // Front: decode, position tracking, palette lookup
   pps_front #(
      .DEST_WIDTH    (DEST_WIDTH),
      .DEST_HEIGHT   (DEST_HEIGHT),
      .REPEAT_PERIOD (REPEAT_PERIOD),
      .PAL_ENTRIES   (PAL_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // Work queue
   pps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // Back: write sequencing and response register
   pps_back #(
      .DEST_WIDTH (DEST_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

@@ bench/pps_write_checker.sv @@
// pps_write_checker: watches the request and response channels of the palette pixel scaler,
// predicts the destination writes of each accepted request and compares them in order.
// Depends on pps_pkg for the payload types and function codes.
`timescale 1ns / 1ps

module pps_write_checker
   import pps_pkg::*;
#(
   parameter int DEST_WIDTH    = 320,
   parameter int DEST_HEIGHT   = 240,
   parameter int REPEAT_PERIOD = 5,
   parameter int PAL_ENTRIES   = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              mismatch_count,
   output int              writes_pending
);

   // Shadow copy of the scaler state
   logic [COLOUR_W-1:0] palette_rgb565 [PAL_ENTRIES];
   int                  col_pos;
   int                  row_pos;
   int                  row_phase;

   // Destination writes still owed by the block, oldest first
   rsp_payload_type     expected_writes_q [$];

   initial begin
      mismatch_count = 0;
      writes_pending = 0;
      col_pos        = 0;
      row_pos        = 0;
      row_phase      = 0;
   end

   task report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Update the shadow state for one request and queue the writes it causes
   task predict_pixel_writes(input req_payload_type r);
      rsp_payload_type wr;
      logic [COLOUR_W-1:0] colour;
      logic repeat_row;
      logic dup;
      case (pps_func_type'(r.func))
         FUNC_PAL_WRITE: begin
            if (r.pal_slot < PAL_ENTRIES)
               palette_rgb565[r.pal_slot] = {r.red[7:3], r.green[7:2], r.blue[7:3]};
         end
         FUNC_FRAME_START: begin
            col_pos   = 0;
            row_pos   = 0;
            row_phase = r.first_row % REPEAT_PERIOD;
         end
         FUNC_PIXEL: begin
            repeat_row = (row_phase == 0);
            colour     = (r.pix_index < PAL_ENTRIES) ? palette_rgb565[r.pix_index] : '0;
            if (row_pos < DEST_HEIGHT && col_pos < DEST_WIDTH) begin
               // duplicate on the row below, unless that row is off the frame
               dup          = repeat_row && (row_pos + 1 < DEST_HEIGHT);
               wr.dest_addr = addr_type'(row_pos * DEST_WIDTH + col_pos);
               wr.colour    = colour;
               wr.last      = !dup;
               expected_writes_q.push_back(wr);
               if (dup) begin
                  wr.dest_addr = addr_type'((row_pos + 1) * DEST_WIDTH + col_pos);
                  wr.last      = 1'b1;
                  expected_writes_q.push_back(wr);
               end
            end
            if (col_pos < DEST_WIDTH)
               col_pos++;
            if (r.last_in_row) begin
               col_pos = 0;
               row_pos += repeat_row ? 2 : 1;
               if (row_pos > DEST_HEIGHT)
                  row_pos = DEST_HEIGHT;
               row_phase = (row_phase + 1) % REPEAT_PERIOD;
            end
         end
         default: ; // unused code: no effect
      endcase
   endtask

   task check_pixel_write(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_writes_q.size() == 0) begin
         report_mismatch($sformatf("unexpected write addr=%0d colour=%04h last=%0b",
                                   got.dest_addr, got.colour, got.last));
      end else begin
         want = expected_writes_q.pop_front();
         if (got.dest_addr !== want.dest_addr)
            report_mismatch($sformatf("dest_addr got %0d want %0d",
                                      got.dest_addr, want.dest_addr));
         if (got.colour !== want.colour)
            report_mismatch($sformatf("colour got %04h want %04h at addr %0d",
                                      got.colour, want.colour, want.dest_addr));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b at addr %0d",
                                      got.last, want.last, want.dest_addr));
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         col_pos   = 0;
         row_pos   = 0;
         row_phase = 0;
         expected_writes_q.delete();
      end else begin
         if (req_valid && req_ready)
            predict_pixel_writes(req_payload);
         if (rsp_valid && rsp_ready)
            check_pixel_write(rsp_payload);
      end
      writes_pending = expected_writes_q.size();
   end

endmodule

@@ bench/tb_palette_pixel_scaler_core.sv @@
// tb_palette_pixel_scaler_core: drives palette writes, frame starts and pixel rows into the
// scaler with random idling on both channels; pps_write_checker predicts and compares.
// Depends on pps_pkg, pps_stream_if, palette_pixel_scaler_core and pps_write_checker.
`timescale 1ns / 1ps

module tb_palette_pixel_scaler_core;
   import pps_pkg::*;

   localparam int          RANDOM_ITEMS   = 900;
   localparam int          TIMEOUT_CYCLES = 600000;
   localparam int          DRAIN_CYCLES   = 20;
   localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   writes_pending;
   int   accepted_items;
   int   cycle_count;
   bit   burst_tx;

   pps_stream_if #(.payload_type(req_payload_type)) req_if ();
   pps_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   palette_pixel_scaler_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   pps_write_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_payload    (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_payload    (rsp_if.payload),
      .mismatch_count (mismatch_count),
      .writes_pending (writes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Response back-pressure: random stalls, with stretches of steady ready
   initial begin
      int  stall_left;
      int  seg_left;
      int  n;
      bit  steady;
      stall_left   = 0;
      seg_left     = 0;
      steady       = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (seg_left == 0) begin
            seg_left = $urandom_range(40, 300);
            steady   = ($urandom_range(0, 3) == 0);
         end
         seg_left--;
         if (steady) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            n = $urandom_range(0, 99);
            if (n < 75) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               stall_left = (n < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
         end
      end
   end

   function automatic int pick_gap();
      int n;
      if ($urandom_range(0, 99) == 0)
         burst_tx = !burst_tx;
      if (burst_tx)
         return 0;
      n = $urandom_range(0, 99);
      if (n < 70) return 0;
      if (n < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_payload_type random_request();
      logic [63:0]     bits;
      req_payload_type p;
      bits = {$urandom, $urandom};
      p    = bits[$bits(req_payload_type)-1:0];
      return p;
   endfunction

   // Present one request from a falling edge and hold it until accepted
   task automatic send_request(input req_payload_type p);
      int gap;
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (p.func != FUNC_UNUSED)
         accepted_items++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_pal_write(input logic [3:0] slot, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
      req_payload_type p;
      p          = random_request();
      p.func     = FUNC_PAL_WRITE;
      p.pal_slot = slot;
      p.red      = r;
      p.green    = g;
      p.blue     = b;
      send_request(p);
   endtask

   task automatic send_frame_start(input logic [7:0] first_row);
      req_payload_type p;
      p           = random_request();
      p.func      = FUNC_FRAME_START;
      p.first_row = first_row;
      send_request(p);
   endtask

   task automatic send_pixel(input logic [3:0] idx, input logic eol);
      req_payload_type p;
      p             = random_request();
      p.func        = FUNC_PIXEL;
      p.pix_index   = idx;
      p.last_in_row = eol;
      send_request(p);
   endtask

   // Directed: palette extremes, pixels before any frame start, unused code,
   // frame start phases
   task automatic run_directed();
      req_payload_type p;
      for (int s = 0; s < 16; s++) begin
         case (s)
            0:       send_pal_write(s[3:0], 8'h00, 8'h00, 8'h00);
            1:       send_pal_write(s[3:0], 8'hff, 8'h00, 8'h00);
            2:       send_pal_write(s[3:0], 8'h00, 8'hff, 8'h00);
            3:       send_pal_write(s[3:0], 8'h00, 8'h00, 8'hff);
            4:       send_pal_write(s[3:0], 8'h07, 8'h03, 8'h07);
            15:      send_pal_write(s[3:0], 8'hff, 8'hff, 8'hff);
            default: send_pal_write(s[3:0], 8'($urandom), 8'($urandom), 8'($urandom));
         endcase
      end
      send_pixel(4'd0, 1'b0);
      send_pixel(4'd15, 1'b1);
      p      = '1;
      p.func = FUNC_UNUSED;
      send_request(p);
      send_frame_start(8'd255);
      send_pixel(4'd15, 1'b1);
      send_frame_start(8'd254);
      send_pixel(4'd1, 1'b0);
      send_pixel(4'd2, 1'b1);
   endtask

   // One frame: frame start, then rows of short random length with palette writes
   // and unused-code noise mixed in; a long row may run past the destination width
   task automatic run_frame(input int stop_at, input bit force_long);
      req_payload_type p;
      int  rows;
      int  len;
      int  n;
      bit  eol;
      send_frame_start(8'($urandom));
      rows = $urandom_range(0, 1) ? 215 : $urandom_range(1, 40);
      for (int row = 0; row < rows && accepted_items < stop_at; row++) begin
         if ((force_long && row == 2) || $urandom_range(0, 299) == 0)
            len = $urandom_range(318, 326);
         else
            len = $urandom_range(1, 4);
         // occasionally leave the row open so it runs into the next
         eol = ($urandom_range(0, 29) != 0);
         for (int k = 0; k < len; k++) begin
            n = $urandom_range(0, 19);
            if (n == 0) begin
               send_pal_write(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (n == 1) begin
               p      = random_request();
               p.func = FUNC_UNUSED;
               send_request(p);
            end
            send_pixel(4'($urandom), eol && (k == len - 1));
         end
      end
   endtask

   // Reset and stimulus
   initial begin
      int stop_at;
      bit first_frame;
      reset          = 1'b1;
      burst_tx       = 1'b0;
      accepted_items = 0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      stop_at     = accepted_items + RANDOM_ITEMS;
      first_frame = 1'b1;
      while (accepted_items < stop_at) begin
         run_frame(stop_at, first_frame);
         first_frame = 1'b0;
      end
      req_if.valid <= 1'b0;

      // Drain outstanding writes, then wait out DRAIN_CYCLES for stray ones
      while (writes_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/pps_pkg.sv
hw/rtl/pps_stream_if.sv
hw/rtl/pps_ram.sv
hw/rtl/pps_front.sv
hw/rtl/pps_queue.sv
hw/rtl/pps_back.sv
hw/rtl/palette_pixel_scaler_core.sv
bench/pps_write_checker.sv
bench/tb_palette_pixel_scaler_core.sv
